@@ rtl/toeq_pkg.sv @@
package toeq_pkg;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [15:0] proc_id;
        logic [15:0] entry_time;
        logic [7:0]  entry_state;
    } entry_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] proc_id;
        logic [15:0] entry_time;
        logic [7:0]  entry_state;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_proc_id;
        logic [7:0]  out_state;
        logic [4:0]  occupancy;
    } out_item_t;

endpackage

@@ rtl/toeq_ram.sv @@
module toeq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  toeq_pkg::entry_t    wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output toeq_pkg::entry_t    rdata
);

    toeq_pkg::entry_t mem [DEPTH];
    toeq_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/toeq_ctrl.sv @@
module toeq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int AW          = 4,
    parameter int CW          = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  toeq_pkg::in_item_t    item,
    output logic                  idle,
    output logic                  res_valid,
    input  logic                  res_ready,
    output toeq_pkg::out_item_t   res,
    output logic                  we,
    output logic [AW-1:0]         waddr,
    output toeq_pkg::entry_t      wdata,
    output logic                  re,
    output logic [AW-1:0]         raddr,
    input  toeq_pkg::entry_t      rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_POP,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    toeq_pkg::in_item_t   item_reg, item_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [1:0]           status_reg, status_next;
    logic [15:0]          pid_reg, pid_next;
    logic [7:0]           pst_reg, pst_next;
    logic [CW-1:0]        rd_li, wr_li;
    logic                 later;
    toeq_pkg::entry_t     new_entry;

    // logical slot -> ring address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] li);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(li);
        if (sum >= (CW+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return AW'(sum);
    endfunction

    // shared key compare: stored time strictly after the new one
    assign later = rdata.entry_time > item_reg.entry_time;

    assign new_entry.proc_id     = item_reg.proc_id;
    assign new_entry.entry_time  = item_reg.entry_time;
    assign new_entry.entry_state = item_reg.entry_state;

    assign raddr = phys(head_reg, rd_li);
    assign waddr = phys(head_reg, wr_li);

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pid_next    = pid_reg;
        pst_next    = pst_reg;
        re          = 1'b0;
        rd_li       = '0;
        we          = 1'b0;
        wr_li       = '0;
        wdata       = new_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next   = item;
                    status_next = toeq_pkg::ST_DONE;
                    pid_next    = '0;
                    pst_next    = '0;
                    unique case (item.action) inside
                        toeq_pkg::ACT_APPEND, toeq_pkg::ACT_INSERT:
                        begin
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                status_next = toeq_pkg::ST_FULL;
                                state_next  = S_DONE;
                            end
                            else if (item.action == toeq_pkg::ACT_APPEND)
                            begin
                                pos_next   = count_reg;
                                state_next = S_PUT;
                            end
                            else if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_PUT;
                            end
                            else
                            begin
                                re         = 1'b1;
                                rd_li      = '0;
                                state_next = S_FIRST;
                            end
                        end
                        toeq_pkg::ACT_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = toeq_pkg::ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                re         = 1'b1;
                                rd_li      = '0;
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // front entry later: new entry goes in front; else the back entry is checked
            S_FIRST:
            begin
                re    = 1'b1;
                rd_li = count_reg - CW'(1);
                if (later)
                begin
                    pos_next   = '0;
                    idx_next   = count_reg - CW'(1);
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (!later)
                begin
                    pos_next   = count_reg;
                    state_next = S_PUT;
                end
                else
                begin
                    idx_next   = CW'(1);
                    re         = 1'b1;
                    rd_li      = CW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (later)
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg - CW'(1);
                    re         = 1'b1;
                    rd_li      = count_reg - CW'(1);
                    state_next = S_SHIFT;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    re       = 1'b1;
                    rd_li    = idx_reg + CW'(1);
                end
            end
            S_SHIFT:
            begin
                we    = 1'b1;
                wr_li = idx_reg + CW'(1);
                wdata = rdata;
                if (idx_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    idx_next = idx_reg - CW'(1);
                    re       = 1'b1;
                    rd_li    = idx_reg - CW'(1);
                end
            end
            S_PUT:
            begin
                we         = 1'b1;
                wr_li      = pos_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_POP:
            begin
                pid_next   = rdata.proc_id;
                pst_next   = rdata.entry_state;
                head_next  = phys(head_reg, CW'(1));
                count_next = count_reg - CW'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            item_reg   <= '0;
            idx_reg    <= '0;
            pos_reg    <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            status_reg <= toeq_pkg::ST_DONE;
            pid_reg    <= '0;
            pst_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            item_reg   <= item_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            pid_reg    <= pid_next;
            pst_reg    <= pst_next;
        end
    end

    assign idle              = state_reg == S_IDLE;
    assign res_valid         = state_reg == S_DONE;
    assign res.status        = status_reg;
    assign res.out_proc_id   = pid_reg;
    assign res.out_state     = pst_reg;
    assign res.occupancy     = 5'(count_reg);

endmodule

@@ rtl/time_ordered_event_queue.sv @@
// Channel | Valid        | Ready        | Payload
// item    | item_valid   | item_ready   | item   (action, proc_id, entry_time, entry_state)
// result  | result_valid | result_ready | result (status, out_proc_id, out_state, occupancy)
//
// One item at a time; entries sit in a ring RAM with one read and one write port.
// Append goes through PUT, pop through POP; add to full or pop on empty goes straight to DONE.
// Sorted insert checks the front and back entries, then scans and shifts; the RAM read port scans
// and moves one entry per cycle.
// Reset clears the entry count; no clearing pass over the RAM.
// A result waits in the output register; the next item is taken meanwhile.
module time_ordered_event_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  toeq_pkg::in_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output toeq_pkg::out_item_t  result
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                 idle;
    logic                 res_valid;
    logic                 slot_free;
    toeq_pkg::out_item_t  res;
    logic                 we, re;
    logic [AW-1:0]        waddr, raddr;
    toeq_pkg::entry_t     wdata, rdata;
    logic                 out_valid_reg, out_valid_next;
    toeq_pkg::out_item_t  out_reg, out_next;

    toeq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    toeq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .idle       (idle),
        .res_valid  (res_valid),
        .res_ready  (slot_free),
        .res        (res),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .re         (re),
        .raddr      (raddr),
        .rdata      (rdata)
    );

    assign item_ready = idle;
    assign slot_free  = !out_valid_reg || result_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && slot_free)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ rtl/toeq_chk.sv @@
module toeq_chk #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input toeq_pkg::in_item_t   item,
    input logic                 result_valid,
    input logic                 result_ready,
    input toeq_pkg::out_item_t  result
);

    // stalled transfer holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while busy");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == toeq_pkg::ST_EMPTY
        |-> result.occupancy == 5'd0 && result.out_proc_id == 16'd0
            && result.out_state == 8'd0)
        else $error("bad empty-pop result");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == toeq_pkg::ST_FULL
        |-> result.occupancy == 5'(QUEUE_DEPTH) && result.out_proc_id == 16'd0)
        else $error("bad full-add result");

endmodule

bind time_ordered_event_queue toeq_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (.*);

@@ tb/sv/time_ordered_event_queue_tb.sv @@
`timescale 1ns / 1ps

module time_ordered_event_queue_tb;

    localparam int DEPTH = 16;
    localparam int RANDOM_ITEMS = 1235;
    localparam int SETTLE_CYCLES = 40;
    localparam longint LIMIT_NS = 64'd8_000_000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        toeq_pkg::in_item_t  it;
        int                  reps;
        bit                  typed;
        toeq_pkg::out_item_t want;
    } plan_row_t;

    logic                rst_n = 1'b0;
    logic                clk = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    toeq_pkg::in_item_t  item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    toeq_pkg::out_item_t result;

    toeq_pkg::entry_t    held_entries[DEPTH];
    int                  held_count = 0;
    toeq_pkg::out_item_t pending_outcomes[$];
    plan_row_t           directed[$];

    int fail_count = 0;
    int results_seen = 0;
    int useful_items = 0;
    int full_hits = 0;
    int empty_hits = 0;
    int unused_hits = 0;
    int peak_count = 0;
    int action_hits[4] = '{0, 0, 0, 0};
    bit sender_calm = 1'b0;

    time_ordered_event_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always #6 clk = ~clk;

    function automatic toeq_pkg::in_item_t mk(logic [1:0] action, logic [15:0] id,
                                              logic [15:0] t, logic [7:0] st);
        toeq_pkg::in_item_t it;
        it.action = action;
        it.proc_id = id;
        it.entry_time = t;
        it.entry_state = st;
        return it;
    endfunction

    function automatic toeq_pkg::out_item_t res(logic [1:0] status, logic [15:0] id,
                                                logic [7:0] st, logic [4:0] occ);
        toeq_pkg::out_item_t r;
        r.status = status;
        r.out_proc_id = id;
        r.out_state = st;
        r.occupancy = occ;
        return r;
    endfunction

    task automatic add_step(input toeq_pkg::in_item_t it, input int reps, input bit typed,
                            input toeq_pkg::out_item_t want);
        plan_row_t row;
        row.it = it;
        row.reps = reps;
        row.typed = typed;
        row.want = want;
        directed.push_back(row);
    endtask

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic toeq_pkg::out_item_t apply_action(toeq_pkg::in_item_t it);
        toeq_pkg::out_item_t r;
        toeq_pkg::entry_t    e;
        int                  pos;
        int                  i;
        r = '0;
        r.status = toeq_pkg::ST_DONE;
        e.proc_id = it.proc_id;
        e.entry_time = it.entry_time;
        e.entry_state = it.entry_state;
        case (it.action)
            toeq_pkg::ACT_APPEND, toeq_pkg::ACT_INSERT:
            begin
                if (held_count >= DEPTH)
                begin
                    r.status = toeq_pkg::ST_FULL;
                end
                else
                begin
                    if (it.action == toeq_pkg::ACT_APPEND || held_count == 0)
                        pos = held_count;
                    else if (it.entry_time < held_entries[0].entry_time)
                        pos = 0;
                    else if (it.entry_time >= held_entries[held_count - 1].entry_time)
                        pos = held_count;
                    else
                    begin
                        // first later entry; queue may be unordered after appends
                        pos = held_count;
                        for (i = held_count - 1; i >= 1; i--)
                            if (held_entries[i].entry_time > it.entry_time)
                                pos = i;
                    end
                    for (i = held_count; i > pos; i--)
                        held_entries[i] = held_entries[i - 1];
                    held_entries[pos] = e;
                    held_count++;
                end
            end
            toeq_pkg::ACT_POP:
            begin
                if (held_count == 0)
                begin
                    r.status = toeq_pkg::ST_EMPTY;
                end
                else
                begin
                    r.out_proc_id = held_entries[0].proc_id;
                    r.out_state = held_entries[0].entry_state;
                    for (i = 1; i < held_count; i++)
                        held_entries[i - 1] = held_entries[i];
                    held_count--;
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = held_count[4:0];
        return r;
    endfunction

    function automatic toeq_pkg::in_item_t rand_item(int add_pct);
        toeq_pkg::in_item_t it;
        int                 r;
        it.proc_id = 16'($urandom);
        it.entry_state = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            it.entry_time = 16'($urandom);
        else
            it.entry_time = 16'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 2)
            it.action = ACT_UNUSED;
        else if (r < add_pct)
            it.action = ($urandom_range(0, 9) < 3) ? toeq_pkg::ACT_APPEND
                                                   : toeq_pkg::ACT_INSERT;
        else
            it.action = toeq_pkg::ACT_POP;
        return it;
    endfunction

    task automatic offer(input toeq_pkg::in_item_t it, input bit typed,
                         input toeq_pkg::out_item_t want);
        int                  gap;
        toeq_pkg::out_item_t predicted;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        predicted = apply_action(it);
        pending_outcomes.push_back(typed ? want : predicted);
        action_hits[it.action]++;
        if (predicted.status == toeq_pkg::ST_FULL)
            full_hits++;
        else if (predicted.status == toeq_pkg::ST_EMPTY)
            empty_hits++;
        else if (it.action == ACT_UNUSED)
            unused_hits++;
        else
            useful_items++;
        if (held_count > peak_count)
            peak_count = held_count;
    endtask

    initial
    begin : result_sink
        int                  stall_left;
        bit                  calm;
        bit                  held_early;
        bit                  held_late;
        toeq_pkg::out_item_t want;
        stall_left = 0;
        calm = 1'b0;
        held_early = 1'b0;
        held_late = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (pending_outcomes.size() == 0)
                begin
                    $error("result transfer with nothing expected: %p", result);
                    fail_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        fail_count++;
                    end
                    if (result.out_proc_id !== want.out_proc_id)
                    begin
                        $error("out_proc_id: expected 0x%04h, got 0x%04h",
                               want.out_proc_id, result.out_proc_id);
                        fail_count++;
                    end
                    if (result.out_state !== want.out_state)
                    begin
                        $error("out_state: expected 0x%02h, got 0x%02h",
                               want.out_state, result.out_state);
                        fail_count++;
                    end
                    if (result.occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, result.occupancy);
                        fail_count++;
                    end
                end
            end
            // long hold-offs so the input side backs up
            if (!held_early && results_seen >= 100)
            begin
                held_early = 1'b1;
                stall_left = 300;
            end
            else if (!held_late && results_seen >= 800)
            begin
                held_late = 1'b1;
                stall_left = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    calm = !calm;
                if (!calm && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    stall_left--;
                    result_ready <= 1'b0;
                end
                else
                begin
                    result_ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("time_ordered_event_queue regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int                  n;
        int                  r;
        int                  add_pct;
        toeq_pkg::out_item_t none;
        none = '0;

        add_step(mk(toeq_pkg::ACT_POP, 16'h0, 16'h0, 8'h0), 1, 1,
                 res(toeq_pkg::ST_EMPTY, 16'h0, 8'h0, 5'd0));
        add_step(mk(ACT_UNUSED, 16'hffff, 16'hffff, 8'hff), 1, 1,
                 res(toeq_pkg::ST_DONE, 16'h0, 8'h0, 5'd0));
        add_step(mk(toeq_pkg::ACT_APPEND, 16'hffff, 16'hffff, 8'hff), 1, 1,
                 res(toeq_pkg::ST_DONE, 16'h0, 8'h0, 5'd1));
        add_step(mk(toeq_pkg::ACT_INSERT, 16'h0, 16'h0, 8'h0), 1, 1,
                 res(toeq_pkg::ST_DONE, 16'h0, 8'h0, 5'd2));
        add_step(mk(toeq_pkg::ACT_INSERT, 16'h0001, 16'h8000, 8'h55), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_INSERT, 16'h0002, 16'h8000, 8'haa), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_INSERT, 16'h0003, 16'hffff, 8'h01), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_POP, 16'h0, 16'h0, 8'h0), 1, 1,
                 res(toeq_pkg::ST_DONE, 16'h0, 8'h0, 5'd4));
        add_step(mk(toeq_pkg::ACT_POP, 16'h0, 16'h0, 8'h0), 4, 0, none);
        add_step(mk(toeq_pkg::ACT_POP, 16'h0, 16'h0, 8'h0), 1, 1,
                 res(toeq_pkg::ST_EMPTY, 16'h0, 8'h0, 5'd0));
        // appends leave the queue out of order, then sorted inserts land in it
        add_step(mk(toeq_pkg::ACT_APPEND, 16'h0010, 16'h0500, 8'h10), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_APPEND, 16'h0011, 16'h0100, 8'h11), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_APPEND, 16'h0012, 16'h0900, 8'h12), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_INSERT, 16'h0013, 16'h0300, 8'h13), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_INSERT, 16'h0014, 16'h0700, 8'h14), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_INSERT, 16'h0015, 16'h0900, 8'h15), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_POP, 16'h0, 16'h0, 8'h0), 6, 0, none);
        // front later than new time, back not: new entry goes in front
        add_step(mk(toeq_pkg::ACT_APPEND, 16'h0020, 16'h0500, 8'h20), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_APPEND, 16'h0021, 16'h0100, 8'h21), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_INSERT, 16'h0022, 16'h0300, 8'h22), 1, 0, none);
        add_step(mk(toeq_pkg::ACT_POP, 16'h0, 16'h0, 8'h0), 3, 0, none);
        add_step(mk(toeq_pkg::ACT_APPEND, 16'haaaa, 16'h1234, 8'h5a), DEPTH, 0, none);
        add_step(mk(toeq_pkg::ACT_APPEND, 16'h5555, 16'h0, 8'ha5), 1, 1,
                 res(toeq_pkg::ST_FULL, 16'h0, 8'h0, 5'(DEPTH)));
        add_step(mk(toeq_pkg::ACT_INSERT, 16'h5555, 16'h0, 8'ha5), 1, 1,
                 res(toeq_pkg::ST_FULL, 16'h0, 8'h0, 5'(DEPTH)));
        add_step(mk(ACT_UNUSED, 16'h0, 16'h0, 8'h0), 1, 1,
                 res(toeq_pkg::ST_DONE, 16'h0, 8'h0, 5'(DEPTH)));
        add_step(mk(toeq_pkg::ACT_POP, 16'h0, 16'h0, 8'h0), DEPTH, 0, none);
        add_step(mk(toeq_pkg::ACT_POP, 16'h0, 16'h0, 8'h0), 1, 1,
                 res(toeq_pkg::ST_EMPTY, 16'h0, 8'h0, 5'd0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            for (r = 0; r < directed[k].reps; r++)
                offer(directed[k].it, directed[k].typed, directed[k].want);

        add_pct = 50;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: add_pct = 85;
                    1: add_pct = 52;
                    default: add_pct = 20;
                endcase
                sender_calm = ($urandom_range(0, 3) == 0);
            end
            offer(rand_item(add_pct), 1'b0, none);
        end
        item_valid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d appends, %0d sorted inserts, %0d pops, %0d unused codes",
                 action_hits[toeq_pkg::ACT_APPEND], action_hits[toeq_pkg::ACT_INSERT],
                 action_hits[toeq_pkg::ACT_POP], action_hits[ACT_UNUSED]);
        $display("%0d results checked (%0d changed the queue), %0d adds refused full, %0d pops on empty, peak %0d",
                 results_seen, useful_items, full_hits, empty_hits, peak_count);
        if (fail_count == 0)
            $display("time_ordered_event_queue regression: pass");
        else
            $display("time_ordered_event_queue regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/toeq_pkg.sv
rtl/toeq_ram.sv
rtl/toeq_ctrl.sv
rtl/time_ordered_event_queue.sv
rtl/toeq_chk.sv
tb/sv/time_ordered_event_queue_tb.sv
